FILE: rtl/ntt_pkg.sv
// Shared types, constants and helper functions for the NTT transform engine.
// Depends on nothing; every other file in rtl/ but ntt_ram imports it.
package ntt_pkg;

    localparam int COEFF_BITS = 23;
    localparam int LANES      = 4;
    localparam int MAX_SIZE   = 256;
    localparam int ADDR_BITS  = $clog2(MAX_SIZE);
    localparam int LANE_BITS  = $clog2(LANES);
    localparam int DATA_BITS  = LANES * COEFF_BITS;
    localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;
    localparam int CFG_BITS   = 2;
    localparam int LOG_BITS   = 4;

    localparam logic [CFG_BITS-1:0] CFG_MODULUS  = 2'd0;
    localparam logic [CFG_BITS-1:0] CFG_ROOT     = 2'd1;
    localparam logic [CFG_BITS-1:0] CFG_LOG_SIZE = 2'd2;

    localparam logic [COEFF_BITS-1:0] MODULUS_RESET = 23'd8380417;
    localparam logic [COEFF_BITS-1:0] ROOT_RESET    = 23'd1753;
    localparam logic [LOG_BITS-1:0]   LOG_RESET     = 4'd8;
    localparam logic [COEFF_BITS-1:0] MODULUS_MIN   = 23'd3;
    localparam logic [LOG_BITS-1:0]   LOG_MIN       = 4'd6;
    localparam logic [LOG_BITS-1:0]   LOG_MAX       = 4'd8;

    typedef logic [COEFF_BITS-1:0] coeff_t;

    typedef struct packed {
        logic                   func;
        logic                   last;
        logic [LANES-1:0][COEFF_BITS-1:0] coeff;
    } item_t;

    // Reverse the low lg bits of v (lg between 6 and 8).
    function automatic logic [ADDR_BITS-1:0] rev_bits(input logic [ADDR_BITS-1:0] v,
                                                      input logic [LOG_BITS-1:0] lg);
        logic [ADDR_BITS-1:0] full;
        for (int b = 0; b < ADDR_BITS; b++) begin
            full[ADDR_BITS-1-b] = v[b];
        end
        return full >> (4'(ADDR_BITS) - lg);
    endfunction

endpackage

FILE: rtl/ntt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ntt_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ntt_modmul.sv
// Bit-serial modular multiplier: res = (x * y) mod q, one bit of x per cycle.
// Requires y < q. Depends on ntt_pkg.
module ntt_modmul
    import ntt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  coeff_t x,
    input  coeff_t y,
    input  coeff_t q,
    output logic   done,
    output coeff_t res
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [4:0]            cnt_reg;
    coeff_t                xs_reg;
    coeff_t                y_reg;
    coeff_t                q_reg;
    coeff_t                r_reg;
    logic [COEFF_BITS+1:0] acc;
    logic [COEFF_BITS+1:0] qx;
    logic [COEFF_BITS+1:0] s1;
    logic [COEFF_BITS+1:0] s2;

    // r = 2r + bit*y stays below 3q, so two conditional subtracts reduce it
    always_comb
    begin
        qx  = {2'b00, q_reg};
        acc = {1'b0, r_reg, 1'b0} + (xs_reg[COEFF_BITS-1] ? {2'b00, y_reg} : '0);
        s1  = (acc >= qx) ? acc - qx : acc;
        s2  = (s1 >= qx) ? s1 - qx : s1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(COEFF_BITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            xs_reg <= x;
            y_reg  <= y;
            q_reg  <= q;
            r_reg  <= '0;
        end
        else if (busy_reg)
        begin
            xs_reg <= xs_reg << 1;
            r_reg  <= s2[COEFF_BITS-1:0];
        end
    end

    assign done = done_reg;
    assign res  = r_reg;

endmodule

FILE: rtl/ntt_front.sv
// Front end: accepts input transfers, unpacks and tags them, and holds them
// in a two-entry queue for the back end. Depends on ntt_pkg.
module ntt_front
    import ntt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  q_valid,
    output item_t                 q_item,
    input  logic                  q_pop
);

    item_t      ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    item_t      in_item;
    logic       push;
    logic       pop;

    always_comb
    begin
        in_item.func = s_tuser;
        in_item.last = s_tlast;
        for (int l = 0; l < LANES; l++)
        begin
            in_item.coeff[l] = s_tdata[l*COEFF_BITS +: COEFF_BITS];
        end
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/ntt_back.sv
// Back end: configuration registers, coefficient store, load reduction,
// bit reversal, butterflies, inverse scaling and result output.
// Depends on ntt_pkg, ntt_ram and ntt_modmul.
module ntt_back
    import ntt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_BITS-1:0]   cfg_index,
    input  coeff_t                cfg_data,
    input  logic                  q_valid,
    input  item_t                 q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_BITS-1:0]  out_data,
    output logic                  out_last
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LRED    = 5'd1;
    localparam logic [4:0] S_ROOT    = 5'd2;
    localparam logic [4:0] S_NRED    = 5'd3;
    localparam logic [4:0] S_NSET    = 5'd4;
    localparam logic [4:0] S_PW_CHK  = 5'd5;
    localparam logic [4:0] S_PW_M1   = 5'd6;
    localparam logic [4:0] S_PW_M2   = 5'd7;
    localparam logic [4:0] S_BR_CHK  = 5'd8;
    localparam logic [4:0] S_BR_RA   = 5'd9;
    localparam logic [4:0] S_BR_RB   = 5'd10;
    localparam logic [4:0] S_BR_WA   = 5'd11;
    localparam logic [4:0] S_BR_WB   = 5'd12;
    localparam logic [4:0] S_ST_INIT = 5'd13;
    localparam logic [4:0] S_ST_GO   = 5'd14;
    localparam logic [4:0] S_BF_RA   = 5'd15;
    localparam logic [4:0] S_BF_RB   = 5'd16;
    localparam logic [4:0] S_BF_CAP  = 5'd17;
    localparam logic [4:0] S_BF_MUL  = 5'd18;
    localparam logic [4:0] S_BF_WA   = 5'd19;
    localparam logic [4:0] S_BF_WB   = 5'd20;
    localparam logic [4:0] S_BF_TW   = 5'd21;
    localparam logic [4:0] S_SC_RD   = 5'd22;
    localparam logic [4:0] S_SC_CAP  = 5'd23;
    localparam logic [4:0] S_SC_MUL  = 5'd24;
    localparam logic [4:0] S_SC_WR   = 5'd25;
    localparam logic [4:0] S_OUT_RD  = 5'd26;
    localparam logic [4:0] S_OUT_CAP = 5'd27;
    localparam logic [4:0] S_OUT_PSH = 5'd28;

    coeff_t                modulus_reg;
    coeff_t                root_reg;
    logic [LOG_BITS-1:0]   log_size_reg;

    logic [4:0]            state_reg;
    logic [4:0]            ret_reg;
    logic                  issued_reg;
    item_t                 item_reg;
    logic [LANE_BITS-1:0]  lane_reg;
    logic [5:0]            load_count_reg;
    coeff_t                r_reg;
    coeff_t                ninv_reg;
    coeff_t                pw_base_reg;
    coeff_t                pw_res_reg;
    coeff_t                pw_exp_reg;
    logic [ADDR_BITS:0]    i_reg;
    logic [ADDR_BITS-1:0]  p_reg;
    logic [LOG_BITS-1:0]   s_reg;
    logic [ADDR_BITS:0]    k_reg;
    logic [ADDR_BITS-1:0]  j_reg;
    coeff_t                tw_reg;
    coeff_t                wm_reg;
    coeff_t                u_reg;
    coeff_t                v_reg;
    coeff_t                t_reg;
    logic [5:0]            o_reg;
    logic [LANES-1:0][COEFF_BITS-1:0] lanes_reg;
    logic                  out_valid_reg;
    logic [DATA_BITS-1:0]  out_data_reg;
    logic                  out_last_reg;

    coeff_t                q_eff;
    logic [LOG_BITS-1:0]   lg_eff;
    logic [ADDR_BITS:0]    n_w;
    logic [6:0]            items_w;
    logic [5:0]            ptr_w;
    logic [ADDR_BITS:0]    h_w;
    logic [ADDR_BITS:0]    m_w;
    logic [ADDR_BITS:0]    a_lo;
    logic [ADDR_BITS:0]    a_hi;
    logic [COEFF_BITS:0]   bf_sum;
    coeff_t                bf_add;
    coeff_t                bf_sub;
    logic [ADDR_BITS-1:0]  rev_i;

    logic                  mul_state;
    logic                  mm_start;
    coeff_t                mm_x;
    coeff_t                mm_y;
    logic                  mm_done;
    coeff_t                mm_res;

    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    coeff_t                ram_wdata;
    logic [ADDR_BITS-1:0]  ram_raddr;
    coeff_t                ram_rdata;
    logic                  out_free;

    // effective configuration
    always_comb
    begin
        q_eff = (modulus_reg < MODULUS_MIN) ? MODULUS_MIN : modulus_reg;
        if (log_size_reg < LOG_MIN)
            lg_eff = LOG_MIN;
        else if (log_size_reg > LOG_MAX)
            lg_eff = LOG_MAX;
        else
            lg_eff = log_size_reg;
        n_w     = (ADDR_BITS+1)'(1) << lg_eff;
        items_w = 7'(n_w >> LANE_BITS);
        ptr_w   = load_count_reg & 6'(items_w - 7'd1);
        h_w     = (ADDR_BITS+1)'(1) << (s_reg - 4'd1);
        m_w     = h_w << 1;
        a_lo    = k_reg + {1'b0, j_reg};
        a_hi    = a_lo + h_w;
        bf_sum  = {1'b0, u_reg} + {1'b0, t_reg};
        bf_add  = (bf_sum >= {1'b0, q_eff}) ? COEFF_BITS'(bf_sum - {1'b0, q_eff})
                                            : bf_sum[COEFF_BITS-1:0];
        bf_sub  = (u_reg >= t_reg) ? u_reg - t_reg : u_reg + (q_eff - t_reg);
        rev_i   = rev_bits(i_reg[ADDR_BITS-1:0], lg_eff);
    end

    // multiplier operand selection
    always_comb
    begin
        mul_state = 1'b1;
        mm_x      = tw_reg;
        mm_y      = coeff_t'(1);
        unique case (state_reg)
            S_LRED:   mm_x = item_reg.coeff[lane_reg];
            S_ROOT:   mm_x = root_reg;
            S_NRED:   mm_x = COEFF_BITS'(n_w);
            S_PW_M1:
            begin
                mm_x = pw_res_reg;
                mm_y = pw_base_reg;
            end
            S_PW_M2:
            begin
                mm_x = pw_base_reg;
                mm_y = pw_base_reg;
            end
            // stored value may sit at or above q; keep the reduced twiddle as addend
            S_BF_MUL:
            begin
                mm_x = v_reg;
                mm_y = tw_reg;
            end
            S_BF_TW:  mm_y = wm_reg;
            S_SC_MUL:
            begin
                mm_x = u_reg;
                mm_y = ninv_reg;
            end
            default:  mul_state = 1'b0;
        endcase
    end

    assign mm_start = mul_state && !issued_reg;

    // store port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = a_lo[ADDR_BITS-1:0];
        ram_wdata = bf_add;
        ram_raddr = a_lo[ADDR_BITS-1:0];
        unique case (state_reg)
            S_LRED:
            begin
                ram_we    = mm_done;
                ram_waddr = {ptr_w, lane_reg};
                ram_wdata = mm_res;
            end
            S_BR_RA:  ram_raddr = i_reg[ADDR_BITS-1:0];
            S_BR_RB:  ram_raddr = p_reg;
            S_BR_WA:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg[ADDR_BITS-1:0];
                ram_wdata = ram_rdata;
            end
            S_BR_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = p_reg;
                ram_wdata = u_reg;
            end
            S_BF_RB:  ram_raddr = a_hi[ADDR_BITS-1:0];
            S_BF_WA:  ram_we = 1'b1;
            S_BF_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = a_hi[ADDR_BITS-1:0];
                ram_wdata = bf_sub;
            end
            S_SC_RD:  ram_raddr = i_reg[ADDR_BITS-1:0];
            S_SC_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg[ADDR_BITS-1:0];
                ram_wdata = t_reg;
            end
            S_OUT_RD: ram_raddr = {o_reg, lane_reg};
            default:  ram_we = 1'b0;
        endcase
    end

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MODULUS_RESET;
            root_reg     <= ROOT_RESET;
            log_size_reg <= LOG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODULUS:  modulus_reg  <= cfg_data;
                CFG_ROOT:     root_reg     <= cfg_data;
                CFG_LOG_SIZE: log_size_reg <= cfg_data[LOG_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            issued_reg     <= 1'b0;
            load_count_reg <= '0;
            lane_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mm_start)
            begin
                issued_reg <= 1'b1;
            end
            else if (mm_done)
            begin
                issued_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg  <= q_item;
                        lane_reg  <= '0;
                        state_reg <= S_LRED;
                    end
                end
                S_LRED:
                begin
                    if (mm_done)
                    begin
                        lane_reg <= lane_reg + 1'b1;
                        if (lane_reg == LANE_BITS'(LANES - 1))
                        begin
                            if (item_reg.last)
                            begin
                                load_count_reg <= '0;
                                state_reg      <= S_ROOT;
                            end
                            else
                            begin
                                load_count_reg <= (ptr_w + 6'd1) & 6'(items_w - 7'd1);
                                state_reg      <= S_IDLE;
                            end
                        end
                    end
                end
                S_ROOT:
                begin
                    if (mm_done)
                    begin
                        i_reg <= '0;
                        if (item_reg.func)
                        begin
                            pw_base_reg <= mm_res;
                            pw_res_reg  <= coeff_t'(1);
                            pw_exp_reg  <= q_eff - coeff_t'(2);
                            ret_reg     <= S_NRED;
                            state_reg   <= S_PW_CHK;
                        end
                        else
                        begin
                            r_reg     <= mm_res;
                            state_reg <= S_BR_CHK;
                        end
                    end
                end
                S_NRED:
                begin
                    if (mm_done)
                    begin
                        r_reg       <= pw_res_reg;
                        pw_base_reg <= mm_res;
                        pw_res_reg  <= coeff_t'(1);
                        pw_exp_reg  <= q_eff - coeff_t'(2);
                        ret_reg     <= S_NSET;
                        state_reg   <= S_PW_CHK;
                    end
                end
                S_NSET:
                begin
                    ninv_reg  <= pw_res_reg;
                    i_reg     <= '0;
                    state_reg <= S_BR_CHK;
                end
                S_PW_CHK:
                begin
                    if (pw_exp_reg == '0)
                        state_reg <= ret_reg;
                    else if (pw_exp_reg[0])
                        state_reg <= S_PW_M1;
                    else
                        state_reg <= S_PW_M2;
                end
                S_PW_M1:
                begin
                    if (mm_done)
                    begin
                        pw_res_reg <= mm_res;
                        state_reg  <= S_PW_M2;
                    end
                end
                S_PW_M2:
                begin
                    if (mm_done)
                    begin
                        pw_base_reg <= mm_res;
                        pw_exp_reg  <= pw_exp_reg >> 1;
                        state_reg   <= S_PW_CHK;
                    end
                end
                S_BR_CHK:
                begin
                    if (i_reg == n_w)
                    begin
                        s_reg     <= 4'd1;
                        state_reg <= S_ST_INIT;
                    end
                    else if ({1'b0, rev_i} > i_reg)
                    begin
                        p_reg     <= rev_i;
                        state_reg <= S_BR_RA;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_BR_RA:  state_reg <= S_BR_RB;
                S_BR_RB:
                begin
                    u_reg     <= ram_rdata;
                    state_reg <= S_BR_WA;
                end
                S_BR_WA:  state_reg <= S_BR_WB;
                S_BR_WB:
                begin
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= S_BR_CHK;
                end
                S_ST_INIT:
                begin
                    if (s_reg > lg_eff)
                    begin
                        i_reg     <= '0;
                        o_reg     <= '0;
                        lane_reg  <= '0;
                        state_reg <= item_reg.func ? S_SC_RD : S_OUT_RD;
                    end
                    else
                    begin
                        pw_base_reg <= r_reg;
                        pw_res_reg  <= coeff_t'(1);
                        pw_exp_reg  <= COEFF_BITS'(n_w >> (s_reg - 4'd1));
                        ret_reg     <= S_ST_GO;
                        state_reg   <= S_PW_CHK;
                    end
                end
                S_ST_GO:
                begin
                    wm_reg    <= pw_res_reg;
                    k_reg     <= '0;
                    j_reg     <= '0;
                    tw_reg    <= coeff_t'(1);
                    state_reg <= S_BF_RA;
                end
                S_BF_RA:  state_reg <= S_BF_RB;
                S_BF_RB:
                begin
                    u_reg     <= ram_rdata;
                    state_reg <= S_BF_CAP;
                end
                S_BF_CAP:
                begin
                    v_reg     <= ram_rdata;
                    state_reg <= S_BF_MUL;
                end
                S_BF_MUL:
                begin
                    if (mm_done)
                    begin
                        t_reg     <= mm_res;
                        state_reg <= S_BF_WA;
                    end
                end
                S_BF_WA:  state_reg <= S_BF_WB;
                S_BF_WB:  state_reg <= S_BF_TW;
                S_BF_TW:
                begin
                    if (mm_done)
                    begin
                        state_reg <= S_BF_RA;
                        if ({1'b0, j_reg} + 1'b1 == h_w)
                        begin
                            j_reg  <= '0;
                            tw_reg <= coeff_t'(1);
                            k_reg  <= k_reg + m_w;
                            if (k_reg + m_w == n_w)
                            begin
                                s_reg     <= s_reg + 4'd1;
                                state_reg <= S_ST_INIT;
                            end
                        end
                        else
                        begin
                            j_reg  <= j_reg + 1'b1;
                            tw_reg <= mm_res;
                        end
                    end
                end
                S_SC_RD:  state_reg <= S_SC_CAP;
                S_SC_CAP:
                begin
                    u_reg     <= ram_rdata;
                    state_reg <= S_SC_MUL;
                end
                S_SC_MUL:
                begin
                    if (mm_done)
                    begin
                        t_reg     <= mm_res;
                        state_reg <= S_SC_WR;
                    end
                end
                S_SC_WR:
                begin
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= (i_reg + 1'b1 == n_w) ? S_OUT_RD : S_SC_RD;
                end
                S_OUT_RD: state_reg <= S_OUT_CAP;
                S_OUT_CAP:
                begin
                    lanes_reg[lane_reg] <= ram_rdata;
                    lane_reg            <= lane_reg + 1'b1;
                    state_reg <= (lane_reg == LANE_BITS'(LANES - 1)) ? S_OUT_PSH : S_OUT_RD;
                end
                S_OUT_PSH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= lanes_reg;
                        out_last_reg  <= ({1'b0, o_reg} == items_w - 7'd1);
                        o_reg         <= o_reg + 6'd1;
                        state_reg <= ({1'b0, o_reg} == items_w - 7'd1) ? S_IDLE : S_OUT_RD;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    ntt_ram #(
        .WIDTH (COEFF_BITS),
        .DEPTH (MAX_SIZE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ntt_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .x     (mm_x),
        .y     (mm_y),
        .q     (q_eff),
        .done  (mm_done),
        .res   (mm_res)
    );

endmodule

FILE: rtl/ntt_transform_engine.sv
// Top level of the NTT transform engine: stream ports and configuration port.
// Depends on ntt_pkg, ntt_front and ntt_back.
//
// Usage: write modulus (index 0), root (index 1) and log_size (index 2) on the
// cfg port while the engine is idle. Stream in n/4 transfers of four
// coefficients each (n = 64, 128 or 256); s_tlast on the final transfer starts
// the transform and s_tuser on that transfer selects forward (0) or inverse (1).
// Coefficients are reduced mod q on load. The result vector comes out on the
// master side as n/4 transfers in natural order, with m_tlast on the last.
// All modular products go through one bit-serial multiplier: the reduction
// of each loaded coefficient, the stage twiddle powers, the butterflies, the
// root and n inverse exponentiation and, for an inverse, the scaling of each
// coefficient. A two-entry input queue keeps taking transfers while the back
// end works, until both of its entries are full.
// Reset clears the queue, the load pointer and the control state and restores
// the default configuration; the coefficient store itself is not cleared.
// A stalled receiver holds the result register and pauses the output sweep.
module ntt_transform_engine
    import ntt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // coeff0, coeff1, coeff2, coeff3, zero pad
    input  logic                  s_tuser,   // func
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // res0, res1, res2, res3, zero pad
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_BITS-1:0]   cfg_index,
    input  coeff_t                cfg_data
);

    logic                 q_valid;
    item_t                q_item;
    logic                 q_pop;
    logic [DATA_BITS-1:0] res_data;

    // input side: unpack and queue each transfer
    ntt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // work side: store, arithmetic and result register
    ntt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data),
        .out_last  (m_tlast)
    );

    // pad the result lanes out to whole bytes
    assign m_tdata = {{(TDATA_BITS - DATA_BITS){1'b0}}, res_data};

endmodule
